[hdl/crc8fl_pkg.sv]
// ----------------------------------------------------------------------------
// crc8fl_pkg: shared definitions for the CRC-8 framed link receiver
// CRC constants, command and event codes, and the CRC-8 byte step.
// ----------------------------------------------------------------------------
package crc8fl_pkg;

  localparam logic [7:0] CRC_POLY   = 8'h97;
  localparam logic [7:0] ALL_ONES   = 8'hFF;
  localparam logic [2:0] LEAD_BYTES = 3'd5;
  localparam int         BYTE_W     = 8;
  localparam int         WORD_W     = 32;
  localparam logic [WORD_W-1:0] ADDR_STEP = 32'd4;

  // command byte codes
  localparam logic [7:0] CMD_SET_ADDR = 8'd1;
  localparam logic [7:0] CMD_WRITE    = 8'd2;
  localparam logic [7:0] CMD_ACK      = 8'd3;
  localparam logic [7:0] CMD_RESYNC   = 8'd4;

  // result event codes
  typedef enum logic [2:0] {
    EV_ADDR_SET  = 3'd0,
    EV_WRITE     = 3'd1,
    EV_ACK       = 3'd2,
    EV_RESYNC    = 3'd3,
    EV_OOB       = 3'd4,
    EV_CHECK_ERR = 3'd5,
    EV_RX_ERR    = 3'd6,
    EV_REMOTE_RST = 3'd7
  } event_t;

  // Divide one byte eight times by the polynomial, MSB first
  function automatic logic [7:0] crc_tab(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

[hdl/crc8_framed_link_receiver.sv]
// ----------------------------------------------------------------------------
// crc8_framed_link_receiver: byte-wide receiver for six-byte CRC-8 frames
// The result for a check byte (or an errored byte) is registered and shown
// on the master side in the cycle after its transfer. Throughput: one byte
// per cycle while results are taken; a stalled result holds s_tready low.
// Reset (rst, synchronous) enters reset mode with a cleared check and write
// address; the frame byte store is not cleared.
// ----------------------------------------------------------------------------
module crc8_framed_link_receiver
  import crc8fl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser,   // [0] rx_error
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [31:0] address, [63:32] word,
                                 // [71:64] checksum, [79:72] command
  output logic [2:0]  m_tuser    // [2:0] event_res
);

  // state
  logic              in_reset_mode, in_reset_mode_next;
  logic [2:0]        byte_position, byte_position_next;
  logic [7:0]        seed_check, seed_check_next;     // T[running check]
  logic [7:0]        partial_check, partial_check_next;
  logic [7:0]        frame_bytes [5];
  logic [WORD_W-1:0] write_address, write_address_next;

  logic              accept;
  logic [7:0]        rx_byte;
  logic              rx_error;
  logic [2:0]        pos;
  logic [7:0]        seed_use;
  logic              frame_we;
  logic              all_ff;
  logic [WORD_W-1:0] word;
  logic [7:0]        cmd;
  logic              emit;
  event_t            ev;
  logic [WORD_W-1:0] res_address;
  logic [WORD_W-1:0] res_word;
  logic [7:0]        res_check;
  logic [7:0]        res_cmd;

  assign rx_byte  = s_tdata;
  assign rx_error = s_tuser[0];
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign word = {frame_bytes[4], frame_bytes[3], frame_bytes[2], frame_bytes[1]};
  assign cmd  = frame_bytes[0];

  // whole-frame 0xFF detect on the check byte
  always_comb begin
    all_ff = (rx_byte == ALL_ONES);
    for (int i = 0; i < 5; i++) begin
      if (frame_bytes[i] != ALL_ONES) begin
        all_ff = 1'b0;
      end
    end
  end

  // decode one received byte
  always_comb begin
    in_reset_mode_next = in_reset_mode;
    byte_position_next = byte_position;
    seed_check_next    = seed_check;
    partial_check_next = partial_check;
    write_address_next = write_address;
    frame_we           = 1'b0;
    emit               = 1'b0;
    ev                 = EV_RX_ERR;
    res_address        = '0;
    res_word           = '0;
    res_check          = '0;
    res_cmd            = '0;
    pos                = (byte_position > LEAD_BYTES) ? 3'd0 : byte_position;
    seed_use           = seed_check;

    if (in_reset_mode) begin
      pos      = 3'd0;
      seed_use = crc_tab(8'd0);
    end

    if (in_reset_mode && rx_byte == ALL_ONES) begin
      // skip filler bytes in reset mode
    end else begin
      if (in_reset_mode) begin
        in_reset_mode_next = 1'b0;
        seed_check_next    = seed_use;
        byte_position_next = 3'd0;
      end
      if (rx_error) begin
        byte_position_next = 3'd0;
        emit               = 1'b1;
        ev                 = EV_RX_ERR;
      end else if (pos < LEAD_BYTES) begin
        frame_we           = 1'b1;
        partial_check_next = crc_tab(((pos == 3'd0) ? seed_use : partial_check) ^ rx_byte);
        byte_position_next = pos + 3'd1;
      end else begin
        byte_position_next = 3'd0;
        emit               = 1'b1;
        if (all_ff) begin
          in_reset_mode_next = 1'b1;
          ev                 = EV_REMOTE_RST;
        end else begin
          seed_check_next = crc_tab(partial_check);
          res_word        = word;
          res_check       = partial_check;
          res_cmd         = cmd;
          if (partial_check != rx_byte) begin
            ev = EV_CHECK_ERR;
          end else begin
            unique case (cmd)
              CMD_SET_ADDR: begin
                ev                 = EV_ADDR_SET;
                write_address_next = word;
                res_address        = word;
              end
              CMD_WRITE: begin
                ev                 = EV_WRITE;
                res_address        = write_address;
                write_address_next = write_address + ADDR_STEP;
              end
              CMD_ACK: begin
                ev        = EV_ACK;
                res_check = frame_bytes[1];
              end
              CMD_RESYNC: begin
                ev = EV_RESYNC;
              end
              default: begin
                ev = EV_OOB;
              end
            endcase
          end
        end
      end
    end
  end

  // hold decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reset_mode <= 1'b1;
      byte_position <= 3'd0;
      seed_check    <= crc_tab(8'd0);
      partial_check <= 8'd0;
      write_address <= '0;
    end else if (accept) begin
      in_reset_mode <= in_reset_mode_next;
      byte_position <= byte_position_next;
      seed_check    <= seed_check_next;
      partial_check <= partial_check_next;
      write_address <= write_address_next;
    end
  end

  // store the leading frame bytes
  always_ff @(posedge clk) begin
    if (accept && frame_we) begin
      frame_bytes[pos] <= rx_byte;
    end
  end

  // result register: load on an emitting transfer, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_tdata <= {res_cmd, res_check, res_word, res_address};
      m_tuser <= ev;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= LEAD_BYTES)
    else $error("byte position out of range");

  a_reset_mode_pos: assert property (@(posedge clk) disable iff (rst)
    in_reset_mode |-> byte_position == 3'd0)
    else $error("frame position moved in reset mode");

  a_remote_rst: assert property (@(posedge clk) disable iff (rst)
    (accept && emit && ev == EV_REMOTE_RST) |=> in_reset_mode)
    else $error("remote reset did not enter reset mode");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");
`endif

endmodule
